FILE: design/smsd_pkg.sv
// smsd_pkg: shared types and constants for the sample mean / deviation block
// no dependencies
`default_nettype none
package smsd_pkg;
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FEW   = 2'd1;
	localparam logic [1:0] ST_DROP  = 2'd2;

	// lane control from the sequencer
	typedef struct packed {
		logic clr;      // clear accumulators
		logic acc_sum;  // accumulate sum (pass one)
		logic acc_sq;   // accumulate squared deviation (pass two)
		logic mean_go;  // start mean division
		logic var_go;   // start variance division
	} lane_ctl_t;

	// lane status back to the sequencer
	typedef struct packed {
		logic mean_done;
		logic std_done;
	} lane_sts_t;
endpackage
`default_nettype wire

FILE: design/sample_mean_stddev_pair.sv
// sample_mean_stddev_pair: top level, sample store, sequencer and result merge
// depends on smsd_pkg, smsd_lane
// samples load one per cycle; a word with last starts the two-pass compute:
// pass one sums, mean divide, pass two sums squared deviations, variance divide and root,
// then result load; a single-sample set skips pass two and the variance step
// no input is taken during compute or while a finished set waits on the result register
// reset clears count, flags and sequencer
`default_nettype none
module sample_mean_stddev_pair #(
	parameter int MAX_SAMPLES = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] x_value,
	input  wire logic [31:0] conf_value,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      mean_x,
	output logic [31:0]      mean_conf,
	output logic [31:0]      std_x,
	output logic [31:0]      std_conf,
	output logic [8:0]       sample_count,
	output logic [1:0]       status
);
	import smsd_pkg::*;
	localparam int AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CNTW = $clog2(MAX_SAMPLES + 1);
	localparam logic [2:0] S_LOAD = 3'd0, S_P1 = 3'd1, S_MDIV = 3'd2,
		S_P2 = 3'd3, S_VAR = 3'd4, S_OUT = 3'd5;

	logic [63:0]     mem [MAX_SAMPLES];
	logic [63:0]     rd_q;
	logic [CNTW-1:0] cnt_q, idx_q;
	logic            ovf_q;
	logic [2:0]      st_q;
	logic            rd_v_q;
	logic [1:0]      rd_dly_q;
	logic [1:0]      mdone_q, sdone_q;
	lane_ctl_t       ctl;
	lane_sts_t       sts_x, sts_c;
	logic [31:0]     mx, mc, sx, sc;
	logic            acc;
	logic            full;
	logic            out_free;

	assign full     = (cnt_q == CNTW'(MAX_SAMPLES));
	assign in_ready = (st_q == S_LOAD);
	assign acc      = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	// sample store write and sequential read
	always_ff @(posedge clk) begin
		if (acc && !full) mem[cnt_q[AW-1:0]] <= {conf_value, x_value};
		rd_q <= mem[idx_q[AW-1:0]];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_LOAD; cnt_q <= '0; ovf_q <= 1'b0; idx_q <= '0;
			rd_v_q <= 1'b0; rd_dly_q <= '0; mdone_q <= '0; sdone_q <= '0;
			out_valid <= 1'b0;
		end else begin
			rd_v_q   <= 1'b0;
			rd_dly_q <= {rd_dly_q[0], rd_v_q};
			// result register: load a finished set, drop a taken word
			if (st_q == S_OUT && out_free) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			case (st_q)
				S_LOAD: begin
					if (acc) begin
						if (!full) cnt_q <= cnt_q + 1'b1;
						else ovf_q <= 1'b1;
						if (last) begin
							st_q <= S_P1; idx_q <= '0;
						end
					end
				end
				S_P1, S_P2: begin
					// pass two also waits for the square pipeline to drain
					if (idx_q != cnt_q) begin
						rd_v_q <= 1'b1; idx_q <= idx_q + 1'b1;
					end else if (!rd_v_q && (st_q == S_P1 || rd_dly_q == 2'b00)) begin
						idx_q <= '0; mdone_q <= '0; sdone_q <= '0;
						st_q <= (st_q == S_P1) ? S_MDIV : S_VAR;
					end
				end
				S_MDIV: begin
					mdone_q <= mdone_q | {sts_c.mean_done, sts_x.mean_done};
					if (mdone_q == 2'b11) st_q <= (cnt_q < CNTW'(2)) ? S_OUT : S_P2;
				end
				S_VAR: begin
					sdone_q <= sdone_q | {sts_c.std_done, sts_x.std_done};
					if (sdone_q == 2'b11) st_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						sample_count <= 9'(cnt_q);
						status <= (cnt_q < CNTW'(2)) ? ST_FEW : (ovf_q ? ST_DROP : ST_OK);
						mean_x <= mx; mean_conf <= mc;
						std_x <= (cnt_q < CNTW'(2)) ? '0 : sx;
						std_conf <= (cnt_q < CNTW'(2)) ? '0 : sc;
						cnt_q <= '0; ovf_q <= 1'b0; st_q <= S_LOAD;
					end
				end
				default: st_q <= S_LOAD;
			endcase
		end
	end

	// lane control
	always_comb begin
		ctl.clr     = acc && last;
		ctl.acc_sum = rd_v_q && (st_q == S_P1);
		ctl.acc_sq  = rd_v_q && (st_q == S_P2);
		ctl.mean_go = (st_q == S_P1) && (idx_q == cnt_q) && !rd_v_q;
		ctl.var_go  = (st_q == S_P2) && (idx_q == cnt_q) && !rd_v_q && (rd_dly_q == 2'b00);
	end

	// one lane per component
	smsd_lane #(.CNTW(CNTW)) u_lx (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .value(rd_q[31:0]), .n(cnt_q),
		.sts(sts_x), .mean(mx), .stdv(sx));
	smsd_lane #(.CNTW(CNTW)) u_lc (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .value(rd_q[63:32]), .n(cnt_q),
		.sts(sts_c), .mean(mc), .stdv(sc));
endmodule
`default_nettype wire

FILE: design/smsd_divider.sv
// smsd_divider: restoring divider, one quotient bit per cycle
// depends on nothing
`default_nettype none
module smsd_divider #(
	parameter int NW = 128,
	parameter int DW = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic [NW-1:0]      quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] quo_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;

	assign trial = {rem_q[DW-1:0], quo_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign quo   = quo_q;

	// shift-subtract loop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
				quo_q  <= num;
				rem_q  <= '0;
				den_q  <= den;
			end else if (busy_q) begin
				if (!diff[DW]) begin
					rem_q <= diff;
					quo_q <= {quo_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[NW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: design/smsd_lane.sv
// smsd_lane: per-component sum, squared deviation, divide and floor root
// depends on smsd_pkg, smsd_divider
`default_nettype none
module smsd_lane #(
	parameter int CNTW = 9
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire smsd_pkg::lane_ctl_t ctl,
	input  wire logic [31:0]      value,
	input  wire logic [CNTW-1:0]  n,
	output smsd_pkg::lane_sts_t   sts,
	output logic [31:0]           mean,
	output logic [31:0]           stdv
);
	import smsd_pkg::*;
	localparam int SW = 32 + CNTW;
	logic [SW-1:0]  sum_q;
	logic [127:0]   sq_q;
	logic [31:0]    mean_q;
	logic [32:0]    dev_s1;
	logic           dev_v_s1;
	logic [63:0]    sq_s2;
	logic           sq_v_s2;
	logic           dm_done, dv_done;
	logic [127:0]   dm_quo, dv_quo;
	logic [CNTW-1:0] nm1;
	logic [63:0]    var_sat;
	logic [63:0]    rad_q, rem_q;
	logic [31:0]    root_q;
	logic [5:0]     rcnt_q;
	logic           rbusy_q, rdone_q;
	logic [65:0]    rtrial;

	assign nm1 = n - 1'b1;

	// mean divider and variance divider
	smsd_divider #(.NW(128), .DW(CNTW)) u_dm (
		.clk(clk), .arst_n(arst_n), .start(ctl.mean_go),
		.num(128'(sum_q)), .den(n), .done(dm_done), .quo(dm_quo));
	smsd_divider #(.NW(128), .DW(CNTW)) u_dv (
		.clk(clk), .arst_n(arst_n), .start(ctl.var_go),
		.num(sq_q), .den(nm1), .done(dv_done), .quo(dv_quo));

	assign var_sat = (dv_quo[127:64] != '0) ? '1 : dv_quo[63:0];

	// accumulation with deviation and square pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_v_s1 <= 1'b0;
			sq_v_s2  <= 1'b0;
		end else begin
			dev_v_s1 <= ctl.acc_sq;
			sq_v_s2  <= dev_v_s1;
		end
	end
	always_ff @(posedge clk) begin
		dev_s1 <= ({1'b0, value} >= {1'b0, mean_q}) ? {1'b0, value} - {1'b0, mean_q}
			: {1'b0, mean_q} - {1'b0, value};
		sq_s2 <= dev_s1[31:0] * dev_s1[31:0];
		if (ctl.clr) begin
			sum_q <= '0;
			sq_q  <= '0;
		end else begin
			if (ctl.acc_sum) sum_q <= sum_q + SW'(value);
			if (sq_v_s2) sq_q <= sq_q + 128'(sq_s2);
		end
		if (ctl.clr) mean_q <= '0;
		else if (dm_done) mean_q <= dm_quo[31:0];
	end

	// floor root, one result bit per cycle
	assign rtrial = {rem_q, rad_q[63:62]} - {32'd0, root_q, 2'b01};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rbusy_q <= 1'b0;
			rdone_q <= 1'b0;
			rcnt_q  <= '0;
		end else begin
			rdone_q <= 1'b0;
			if (ctl.clr) begin
				rbusy_q <= 1'b0;
			end else if (dv_done) begin
				rbusy_q <= 1'b1;
				rcnt_q  <= 6'd32;
			end else if (rbusy_q) begin
				rcnt_q <= rcnt_q - 1'b1;
				if (rcnt_q == 6'd1) begin
					rbusy_q <= 1'b0;
					rdone_q <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			root_q <= '0;
		end else if (dv_done) begin
			rad_q  <= var_sat;
			rem_q  <= '0;
			root_q <= '0;
		end else if (rbusy_q) begin
			rad_q <= {rad_q[61:0], 2'b00};
			if (!rtrial[65]) begin
				rem_q  <= rtrial[63:0];
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[61:0], rad_q[63:62]};
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign mean = mean_q;
	assign stdv = root_q;
	assign sts.mean_done = dm_done;
	assign sts.std_done  = rdone_q;
endmodule
`default_nettype wire

FILE: design/smsd_checker.sv
// smsd_checker: port-level assertions for sample_mean_stddev_pair
// depends on smsd_pkg and the top level ports; bound at the end of this file
`default_nettype none
module smsd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] std_x,
	input wire logic [31:0] std_conf,
	input wire logic [8:0]  sample_count,
	input wire logic [1:0]  status
);
	import smsd_pkg::*;
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result word dropped while stalled");
	a_few: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sample_count < 9'd2 |-> status == ST_FEW && std_x == 0 && std_conf == 0)
		else $error("small set result wrong");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("bad status");
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input word withdrawn before accept");
endmodule
bind sample_mean_stddev_pair smsd_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .std_x(std_x), .std_conf(std_conf),
	.sample_count(sample_count), .status(status));
`default_nettype wire
